// ----- hdl/ffha_pkg.sv -----
package ffha_pkg;

  // Datapath operation codes issued by the controller
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_INIT      = 4'd1;
  localparam logic [3:0] OP_ACCEPT    = 4'd2;
  localparam logic [3:0] OP_READ_POS  = 4'd3;
  localparam logic [3:0] OP_ADV       = 4'd4;
  localparam logic [3:0] OP_SPLIT     = 4'd5;
  localparam logic [3:0] OP_MARK_USED = 4'd6;
  localparam logic [3:0] OP_MARK_FREE = 4'd7;
  localparam logic [3:0] OP_M_LATCH   = 4'd8;
  localparam logic [3:0] OP_M_READ_NX = 4'd9;
  localparam logic [3:0] OP_M_MERGE   = 4'd10;
  localparam logic [3:0] OP_M_ADV     = 4'd11;
  localparam logic [3:0] OP_RESULT    = 4'd12;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NOMEM    = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_NOTSTART = 3'd4;
  localparam logic [2:0] ST_DOUBLE   = 3'd5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] code;
  } ffha_cmd_t;

  typedef struct packed {
    logic is_free_cmd;
    logic zero_size;
    logic outside;
    logic pos_end;
    logic pos_past;
    logic pos_hit;
    logic rd_free;
    logic fits;
    logic splits;
    logic cur_free;
    logic nx_end;
    logic out_free;
  } ffha_flags_t;

endpackage

// ----- hdl/ffha_ctrl.sv -----
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  ffha_flags_t flags,
  output ffha_cmd_t   cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_AREAD  = 4'd3;
  localparam logic [3:0] S_ACHK   = 4'd4;
  localparam logic [3:0] S_ASPLIT = 4'd5;
  localparam logic [3:0] S_AMARK  = 4'd6;
  localparam logic [3:0] S_FREAD  = 4'd7;
  localparam logic [3:0] S_FCHK   = 4'd8;
  localparam logic [3:0] S_MREAD  = 4'd9;
  localparam logic [3:0] S_MCUR   = 4'd10;
  localparam logic [3:0] S_MNX    = 4'd11;
  localparam logic [3:0] S_MNEXT  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;
  logic [2:0] code, code_next;

  assign req_stall = (state != S_IDLE);

  // Hold state and pending status code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // Sequence the walk, split, mark and merge steps
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd.op     = OP_NONE;
    cmd.code   = code;
    case (state)
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!flags.is_free_cmd) begin
          if (flags.zero_size) begin
            code_next  = ST_ZERO;
            state_next = S_DONE;
          end else begin
            state_next = S_AREAD;
          end
        end else if (flags.outside) begin
          code_next  = ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          state_next = S_FREAD;
        end
      end
      S_AREAD: begin
        if (flags.pos_end) begin
          code_next  = ST_NOMEM;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_READ_POS;
          state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        if (flags.rd_free && flags.fits) begin
          state_next = flags.splits ? S_ASPLIT : S_AMARK;
        end else begin
          cmd.op     = OP_ADV;
          state_next = S_AREAD;
        end
      end
      S_ASPLIT: begin
        cmd.op     = OP_SPLIT;
        state_next = S_AMARK;
      end
      S_AMARK: begin
        cmd.op     = OP_MARK_USED;
        code_next  = ST_OK;
        state_next = S_DONE;
      end
      S_FREAD: begin
        if (flags.pos_end || flags.pos_past) begin
          code_next  = ST_NOTSTART;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_READ_POS;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (flags.pos_hit) begin
          if (flags.rd_free) begin
            code_next  = ST_DOUBLE;
            state_next = S_DONE;
          end else begin
            cmd.op     = OP_MARK_FREE;
            state_next = S_MREAD;
          end
        end else begin
          cmd.op     = OP_ADV;
          state_next = S_FREAD;
        end
      end
      S_MREAD: begin
        if (flags.pos_end) begin
          code_next  = ST_OK;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_READ_POS;
          state_next = S_MCUR;
        end
      end
      S_MCUR: begin
        cmd.op     = OP_M_LATCH;
        state_next = S_MNX;
      end
      S_MNX: begin
        if (flags.cur_free && !flags.nx_end) begin
          cmd.op     = OP_M_READ_NX;
          state_next = S_MNEXT;
        end else begin
          cmd.op     = OP_M_ADV;
          state_next = S_MREAD;
        end
      end
      S_MNEXT: begin
        if (flags.rd_free) begin
          cmd.op     = OP_M_MERGE;
          state_next = S_MNX;
        end else begin
          cmd.op     = OP_M_ADV;
          state_next = S_MREAD;
        end
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ----- hdl/ffha_dp.sv -----
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  ffha_cmd_t   cmd,
  output ffha_flags_t flags,
  input  logic        command,
  input  logic [12:0] request_size,
  input  logic [11:0] payload_offset,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [11:0] granted_offset,
  output logic [2:0]  status
);

  localparam int GRAN = HEAP_BYTES / 8;
  localparam int SW   = $clog2(GRAN);
  localparam int PW   = $clog2(HEAP_BYTES) + 1;
  localparam int XW   = ((PW > 14) ? PW : 14) + 2;
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] MIN_X  = XW'(HEADER_BYTES + 8);

  // Header store: {payload length, free mark}, one entry per 8-byte granule
  logic [PW:0] mem [GRAN];

  logic          cmd_reg;
  logic [13:0]   want;
  logic          size_zero;
  logic [11:0]   off;
  logic [PW-1:0] hdr;
  logic [PW-1:0] pos;
  logic [PW-1:0] rd_len;
  logic          rd_free;
  logic [PW-1:0] cur_len;
  logic          cur_free;
  logic [11:0]   grant;

  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [PW:0]   wr_data;
  logic          rd_en;
  logic [SW-1:0] rd_addr;

  logic [XW-1:0] pos_x, want_x, len_x, cur_x, off_x;
  logic [XW-1:0] nx_rd_x, nx_cur_x, np_x, merged_x;

  assign pos_x    = XW'(pos);
  assign want_x   = XW'(want);
  assign len_x    = XW'(rd_len);
  assign cur_x    = XW'(cur_len);
  assign off_x    = XW'(off);
  assign nx_rd_x  = pos_x + HDR_X + len_x;
  assign nx_cur_x = pos_x + HDR_X + cur_x;
  assign np_x     = pos_x + HDR_X + want_x;
  assign merged_x = cur_x + HDR_X + len_x;

  // Status toward the controller
  always_comb begin
    flags.is_free_cmd = (cmd_reg == CMD_FREE);
    flags.zero_size   = size_zero;
    flags.outside     = (off_x < HDR_X) || (off_x >= HEAP_X);
    flags.pos_end     = (pos_x >= HEAP_X);
    flags.pos_past    = (pos > hdr);
    flags.pos_hit     = (pos == hdr);
    flags.rd_free     = rd_free;
    flags.fits        = (len_x >= want_x);
    flags.splits      = (len_x >= want_x + MIN_X);
    flags.cur_free    = cur_free;
    flags.nx_end      = (nx_cur_x >= HEAP_X);
    flags.out_free    = !rsp_valid || !rsp_stall;
  end

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos[SW+2:3];
    wr_data = {rd_len, 1'b0};
    rd_en   = 1'b0;
    rd_addr = pos[SW+2:3];
    case (cmd.op)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {PW'(HEAP_BYTES - HEADER_BYTES), 1'b1};
      end
      OP_READ_POS: begin
        rd_en = 1'b1;
      end
      OP_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = np_x[SW+2:3];
        wr_data = {PW'(len_x - want_x - HDR_X), 1'b1};
      end
      OP_MARK_USED: begin
        wr_en   = 1'b1;
        wr_data = {(flags.splits ? PW'(want) : rd_len), 1'b0};
      end
      OP_MARK_FREE: begin
        wr_en   = 1'b1;
        wr_data = {rd_len, 1'b1};
      end
      OP_M_READ_NX: begin
        rd_en   = 1'b1;
        rd_addr = nx_cur_x[SW+2:3];
      end
      OP_M_MERGE: begin
        wr_en   = 1'b1;
        wr_data = {PW'(merged_x), 1'b1};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      {rd_len, rd_free} <= mem[rd_addr];
    end
  end

  // Request, walk position and merge accumulator
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        cmd_reg   <= command;
        want      <= (14'(request_size) + 14'd7) & ~14'd7;
        size_zero <= (request_size == 13'd0);
        off       <= payload_offset;
        hdr       <= PW'(XW'(payload_offset) - HDR_X);
        pos       <= '0;
        grant     <= '0;
      end
      OP_ADV: begin
        pos <= PW'(nx_rd_x);
      end
      OP_MARK_USED: begin
        grant <= 12'(pos_x + HDR_X);
      end
      OP_MARK_FREE: begin
        pos <= '0;
      end
      OP_M_LATCH: begin
        cur_len  <= rd_len;
        cur_free <= rd_free;
      end
      OP_M_MERGE: begin
        cur_len <= PW'(merged_x);
      end
      OP_M_ADV: begin
        pos <= PW'(nx_cur_x);
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      granted_offset <= (cmd.code == ST_OK) ? grant : 12'd0;
      status         <= cmd.code;
    end
  end

endmodule

// ----- hdl/first_fit_heap_allocator_core.sv -----
// Channel    | Handshake               | Payload
// request    | req_valid / req_stall   | command, request_size, payload_offset
// response   | rsp_valid / rsp_stall   | granted_offset, status
//
// One request at a time; each chunk visited on a search walk takes a header
// read, then a test, since the header read is registered.
// Allocate: the walk, a split when the rest can hold another chunk, the used mark,
// then the result. Free: the walk up to the target, the free mark, then a merge
// walk from the heap start that joins each free chunk with free neighbors after it.
// After reset the block writes the initial free chunk; req_stall is high then.
// A finished result waits in the response register while stalled.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        command,
  input  logic [12:0] request_size,
  input  logic [11:0] payload_offset,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [11:0] granted_offset,
  output logic [2:0]  status
);

  ffha_cmd_t   cmd;
  ffha_flags_t flags;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .flags          (flags),
    .command        (command),
    .request_size   (request_size),
    .payload_offset (payload_offset),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .granted_offset (granted_offset),
    .status         (status)
  );

endmodule

// ----- hdl/ffha_chk.sv -----
module ffha_chk
  import ffha_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [11:0] granted_offset,
  input logic [2:0]  status
);

  // Stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_offset) && $stable(status))
    else $error("stalled response changed");

  // Status is a defined code
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_DOUBLE)
    else $error("undefined status code");

  // Failed requests grant nothing
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> granted_offset == 12'd0)
    else $error("offset granted on failure");

  // Accepted request is not followed by another acceptance next cycle
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // Block is busy right after reset
  assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during initialization");

endmodule

bind first_fit_heap_allocator_core ffha_chk u_ffha_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .granted_offset (granted_offset),
  .status         (status)
);
